// ===== rtl/core/command_line_tokenizer_defines.svh =====
// Assertion macros for the command line tokenizer.
`ifndef COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// check on every edge out of reset
`define CLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every edge, reset included
`define CLT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define CLT_ASSERT(lbl, prop, msg)
`define CLT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/cmdtok_pkg.sv =====
// Shared constants, types and character helpers for the command line tokenizer.
package cmdtok_pkg;

    localparam int MAX_TOKENS_DEF  = 6;
    localparam int TOKEN_BYTES_DEF = 12;
    localparam int OUT_ARGS        = 5;
    localparam int ARG_W           = 32;
    localparam int KIND_W          = 2;
    localparam int ARGC_W          = 3;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [1:0] FORM_DEC  = 2'd0;
    localparam logic [1:0] FORM_ZERO = 2'd1;
    localparam logic [1:0] FORM_HEX  = 2'd2;
    localparam logic [1:0] FORM_STOP = 2'd3;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;

    localparam int WRITE_LEN = 5;
    localparam int READ_LEN  = 4;

    typedef struct packed {
        logic [1:0] form;
        logic       neg;
    } t_arg_state;

    function automatic logic [7:0] write_letter(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h77; // w
            3'd1:    ch = 8'h72; // r
            3'd2:    ch = 8'h69; // i
            3'd3:    ch = 8'h74; // t
            3'd4:    ch = 8'h65; // e
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] read_letter(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h72; // r
            2'd1:    ch = 8'h65; // e
            2'd2:    ch = 8'h61; // a
            2'd3:    ch = 8'h64; // d
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/cmdtok_arg_unit.sv =====
// Per-character update of one argument value and its number form.
module cmdtok_arg_unit import cmdtok_pkg::*; (
    input  logic [7:0]       i_char,
    input  logic             i_first,
    input  t_arg_state       i_st,
    input  logic [ARG_W-1:0] i_value,
    output t_arg_state       o_st,
    output logic [ARG_W-1:0] o_value
);

    logic             w_dig;
    logic [3:0]       w_dec;
    logic [4:0]       w_hex;
    logic [ARG_W-1:0] w_times10;
    logic [ARG_W-1:0] w_dec_ext;

    assign w_dig     = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
    assign w_dec     = 4'(i_char - CHAR_ZERO);
    assign w_hex     = hex_digit(i_char);
    assign w_times10 = (i_value << 3) + (i_value << 1);
    assign w_dec_ext = ARG_W'(w_dec);

    always_comb begin
        o_st    = i_st;
        o_value = i_value;
        case (i_st.form)
            FORM_DEC: begin
                if (i_first && i_char == CHAR_ZERO) begin
                    o_st.form = FORM_ZERO;
                end else if (i_first && i_char == CHAR_PLUS) begin
                    o_st = i_st;
                end else if (i_first && i_char == CHAR_MINUS) begin
                    o_st.neg = 1'b1;
                end else if (w_dig) begin
                    o_value = i_st.neg ? (w_times10 - w_dec_ext) : (w_times10 + w_dec_ext);
                end else begin
                    o_st.form = FORM_STOP;
                end
            end
            FORM_ZERO: begin
                if (i_char == CHAR_X) begin
                    o_st.form = FORM_HEX;
                end else if (w_dig) begin
                    o_st.form = FORM_DEC;
                    o_value   = w_dec_ext;
                end else begin
                    o_st.form = FORM_STOP;
                end
            end
            FORM_HEX: begin
                if (w_hex[4]) begin
                    o_value = (i_value << 4) + ARG_W'(w_hex[3:0]);
                end else begin
                    o_st.form = FORM_STOP;
                end
            end
            default: begin
                o_st = i_st;
            end
        endcase
    end

endmodule

// ===== rtl/core/command_line_tokenizer.sv =====
// Command line tokenizer: splits a character stream into a command and arguments.
//
// Input channel (i_char_valid / o_char_ready / i_char_in) moves one byte per
// transfer. Space, tab and carriage return separate tokens; a newline ends the
// line. Every character updates the line state in the cycle it is accepted,
// so the block takes one character per clock, except that a newline waits while a result is stalled.
// Output channel (o_cmd_valid / i_cmd_ready) moves one result per line: the
// command kind (write, read, other), the argument count and five 32-bit
// argument values. The result sits in the output register in the cycle after
// the newline transfer, and it stays there until it is taken.
// While a result waits unread, ordinary characters are still taken; only a
// further newline is held off (o_char_ready low) until the result is taken,
// since the single output register is the only place a result can wait.
// Reset (i_rst_n low, synchronous) clears the line state, the argument
// values and the output valid flag. The argument path is one multiply by ten
// (shift and add) plus one add or subtract per character; hex digits shift by four.
`include "command_line_tokenizer_defines.svh"
module command_line_tokenizer import cmdtok_pkg::*; #(
    parameter int MAX_TOKENS  = MAX_TOKENS_DEF,
    parameter int TOKEN_BYTES = TOKEN_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_char_valid,
    output logic                     o_char_ready,
    input  logic [7:0]               i_char_in,
    output logic                     o_cmd_valid,
    input  logic                     i_cmd_ready,
    output logic [KIND_W-1:0]        o_command_kind,
    output logic [ARGC_W-1:0]        o_arg_count,
    output logic signed [ARG_W-1:0]  o_arg0,
    output logic signed [ARG_W-1:0]  o_arg1,
    output logic signed [ARG_W-1:0]  o_arg2,
    output logic signed [ARG_W-1:0]  o_arg3,
    output logic signed [ARG_W-1:0]  o_arg4
);

    localparam int NARGS  = MAX_TOKENS - 1;
    localparam int CNT_W  = $clog2(MAX_TOKENS + 1);
    localparam int LEN_W  = $clog2(TOKEN_BYTES);
    localparam int SLOT_W = (NARGS > 1) ? $clog2(NARGS) : 1;

    // line state
    logic [CNT_W-1:0] r_tok_cnt, n_tok_cnt;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_wr_cand, n_wr_cand;
    logic             r_rd_cand, n_rd_cand;
    t_arg_state       r_st, n_st;
    logic [ARG_W-1:0] r_arg [NARGS];
    logic [ARG_W-1:0] n_arg [NARGS];

    // result register
    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [ARGC_W-1:0] r_argc;
    logic [ARG_W-1:0]  r_res [OUT_ARGS];

    logic             w_char_fire;
    logic             w_is_sep;
    logic             w_is_lf;
    logic [CNT_W-1:0] w_cnt_eff;
    logic [7:0]       w_len8;
    logic             w_room;
    logic [SLOT_W-1:0] w_slot;
    t_arg_state       w_unit_st;
    logic [ARG_W-1:0] w_unit_val;
    logic             w_wr_close, w_rd_close;
    logic             w_wr_final, w_rd_final;
    logic [KIND_W-1:0] w_kind;
    logic [ARG_W-1:0] w_res_src [OUT_ARGS];

    assign w_is_sep = (i_char_in == CHAR_SPACE) || (i_char_in == CHAR_TAB)
                    || (i_char_in == CHAR_CR);
    assign w_is_lf  = (i_char_in == CHAR_LF);

    // hold off a newline only while the result register is full and stalled
    assign o_char_ready = !w_is_lf || !r_out_valid || i_cmd_ready;
    assign w_char_fire  = i_char_valid && o_char_ready;

    // a line with no tokens yet behaves as one with an empty first token
    assign w_cnt_eff = (r_tok_cnt == '0) ? CNT_W'(1) : r_tok_cnt;
    assign w_len8    = 8'(r_len);
    assign w_room    = (r_len < LEN_W'(TOKEN_BYTES - 1));
    assign w_slot    = SLOT_W'(w_cnt_eff - CNT_W'(2));

    cmdtok_arg_unit u_arg (
        .i_char  (i_char_in),
        .i_first (r_len == '0),
        .i_st    (r_st),
        .i_value (r_arg[w_slot]),
        .o_st    (w_unit_st),
        .o_value (w_unit_val)
    );

    // name closes: only an exact-length prefix match survives
    assign w_wr_close = r_wr_cand && (w_len8 == 8'(WRITE_LEN));
    assign w_rd_close = r_rd_cand && (w_len8 == 8'(READ_LEN));
    assign w_wr_final = (w_cnt_eff == CNT_W'(1)) ? w_wr_close : r_wr_cand;
    assign w_rd_final = (w_cnt_eff == CNT_W'(1)) ? w_rd_close : r_rd_cand;
    assign w_kind     = w_wr_final ? KIND_WRITE : (w_rd_final ? KIND_READ : KIND_OTHER);

    genvar gk;
    generate
        for (gk = 0; gk < OUT_ARGS; gk++) begin : g_res_src
            if (gk < NARGS) begin : g_arg
                assign w_res_src[gk] = r_arg[gk];
            end else begin : g_none
                assign w_res_src[gk] = '0;
            end
        end
    endgenerate

    always_comb begin
        n_tok_cnt = r_tok_cnt;
        n_len     = r_len;
        n_wr_cand = r_wr_cand;
        n_rd_cand = r_rd_cand;
        n_st      = r_st;
        for (int i = 0; i < NARGS; i++) begin
            n_arg[i] = r_arg[i];
        end
        n_out_valid = r_out_valid && !i_cmd_ready;

        if (w_char_fire) begin
            if (w_is_lf) begin
                n_out_valid = 1'b1;
                n_tok_cnt   = '0;
                n_len       = '0;
                n_wr_cand   = 1'b1;
                n_rd_cand   = 1'b1;
                n_st        = '{form: FORM_DEC, neg: 1'b0};
                for (int i = 0; i < NARGS; i++) begin
                    n_arg[i] = '0;
                end
            end else if (w_is_sep) begin
                n_tok_cnt = w_cnt_eff;
                // open a new token unless empty or the token limit is reached
                if (r_len != '0 && w_cnt_eff < CNT_W'(MAX_TOKENS)) begin
                    if (w_cnt_eff == CNT_W'(1)) begin
                        n_wr_cand = w_wr_close;
                        n_rd_cand = w_rd_close;
                    end
                    n_tok_cnt = w_cnt_eff + CNT_W'(1);
                    n_len     = '0;
                    n_st      = '{form: FORM_DEC, neg: 1'b0};
                end
            end else begin
                n_tok_cnt = w_cnt_eff;
                // drop characters beyond the first TOKEN_BYTES - 1 of a token
                if (w_room) begin
                    if (w_cnt_eff == CNT_W'(1)) begin
                        if (w_len8 >= 8'(WRITE_LEN) || write_letter(w_len8[2:0]) != i_char_in)
                        begin
                            n_wr_cand = 1'b0;
                        end
                        if (w_len8 >= 8'(READ_LEN) || read_letter(w_len8[1:0]) != i_char_in)
                        begin
                            n_rd_cand = 1'b0;
                        end
                    end else begin
                        n_st          = w_unit_st;
                        n_arg[w_slot] = w_unit_val;
                    end
                    n_len = r_len + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_cnt   <= '0;
            r_len       <= '0;
            r_wr_cand   <= 1'b1;
            r_rd_cand   <= 1'b1;
            r_st        <= '{form: FORM_DEC, neg: 1'b0};
            r_out_valid <= 1'b0;
            for (int i = 0; i < NARGS; i++) begin
                r_arg[i] <= '0;
            end
        end else begin
            r_tok_cnt   <= n_tok_cnt;
            r_len       <= n_len;
            r_wr_cand   <= n_wr_cand;
            r_rd_cand   <= n_rd_cand;
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
            for (int i = 0; i < NARGS; i++) begin
                r_arg[i] <= n_arg[i];
            end
        end
    end

    // load the result on a newline transfer
    always_ff @(posedge i_clk) begin
        if (w_char_fire && w_is_lf) begin
            r_kind <= w_kind;
            r_argc <= ARGC_W'(w_cnt_eff - CNT_W'(1));
            for (int k = 0; k < OUT_ARGS; k++) begin
                r_res[k] <= w_res_src[k];
            end
        end
    end

    assign o_cmd_valid    = r_out_valid;
    assign o_command_kind = r_kind;
    assign o_arg_count    = r_argc;
    assign o_arg0         = r_res[0];
    assign o_arg1         = r_res[1];
    assign o_arg2         = r_res[2];
    assign o_arg3         = r_res[3];
    assign o_arg4         = r_res[4];

    `CLT_ASSERT(a_lf_no_overwrite,
        (w_char_fire && w_is_lf) |-> (!r_out_valid || i_cmd_ready),
        "newline accepted while an unread result is stalled")
    `CLT_ASSERT(a_valid_from_lf,
        $rose(o_cmd_valid) |-> $past(w_char_fire && w_is_lf),
        "result valid without a newline transfer")
    `CLT_ASSERT(a_line_cleared,
        (w_char_fire && w_is_lf) |=> (r_tok_cnt == '0 && r_len == '0 && o_cmd_valid),
        "line state not cleared after newline")
    `CLT_ASSERT_ALWAYS(a_tok_limit,
        !i_rst_n || (r_tok_cnt <= CNT_W'(MAX_TOKENS)),
        "token count beyond limit")

endmodule

// ===== dv/command_line_checker.sv =====
// Line predictor and result checker for the command line tokenizer.
module command_line_checker import cmdtok_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_char_valid,
    input  logic                    i_char_ready,
    input  logic [7:0]              i_char_in,
    input  logic                    i_cmd_valid,
    input  logic                    i_cmd_ready,
    input  logic [KIND_W-1:0]       i_command_kind,
    input  logic [ARGC_W-1:0]       i_arg_count,
    input  logic signed [ARG_W-1:0] i_arg0,
    input  logic signed [ARG_W-1:0] i_arg1,
    input  logic signed [ARG_W-1:0] i_arg2,
    input  logic signed [ARG_W-1:0] i_arg3,
    input  logic signed [ARG_W-1:0] i_arg4,
    output int                      o_fail_count,
    output int                      o_lines_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOKENS_MAX = MAX_TOKENS_DEF;
    localparam int TOKEN_KEEP = TOKEN_BYTES_DEF - 1;

    localparam logic [8*WRITE_LEN-1:0] WRITE_WORD = "write";
    localparam logic [8*READ_LEN-1:0]  READ_WORD  = "read";
    localparam logic [7:0] LOW_A = "a";
    localparam logic [7:0] LOW_F = "f";
    localparam logic [7:0] UP_A  = "A";
    localparam logic [7:0] UP_F  = "F";

    typedef struct packed {
        logic [KIND_W-1:0]                kind;
        logic [ARGC_W-1:0]                argc;
        logic [OUT_ARGS-1:0][ARG_W-1:0]   args;
    } t_line_result;

    t_line_result lines_due[$];

    // line state as the parser should hold it
    int         tok_count;
    int         tok_len;
    logic       write_ok;
    logic       read_ok;
    logic [ARG_W-1:0] arg_val [OUT_ARGS];
    logic [1:0] form;
    logic       neg;

    initial begin
        o_fail_count    = 0;
        o_lines_pending = 0;
    end

    function automatic void clear_line();
        tok_count = 0;
        tok_len   = 0;
        write_ok  = 1'b1;
        read_ok   = 1'b1;
        for (int k = 0; k < OUT_ARGS; k++) arg_val[k] = '0;
        form = FORM_DEC;
        neg  = 1'b0;
    endfunction

    function automatic void close_name();
        if (tok_len != WRITE_LEN) write_ok = 1'b0;
        if (tok_len != READ_LEN) read_ok = 1'b0;
    endfunction

    function automatic void predict_char(input logic [7:0] c);
        t_line_result res;
        logic         dig;
        logic         hex_ok;
        logic [3:0]   nib;
        logic [31:0]  d;
        int           slot;
        dig = (c >= CHAR_ZERO && c <= CHAR_NINE);
        d   = dig ? 32'(c - CHAR_ZERO) : 32'd0;
        if (tok_count == 0) begin
            tok_count = 1;
            tok_len   = 0;
        end
        if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR) begin
            // skip repeated separators; past the token limit they join the last token
            if (tok_len != 0 && tok_count < TOKENS_MAX) begin
                if (tok_count == 1) close_name();
                tok_count++;
                tok_len = 0;
                form    = FORM_DEC;
                neg     = 1'b0;
            end
        end else if (c == CHAR_LF) begin
            if (tok_count == 1) close_name();
            res.kind = write_ok ? KIND_WRITE : (read_ok ? KIND_READ : KIND_OTHER);
            res.argc = ARGC_W'(tok_count - 1);
            for (int k = 0; k < OUT_ARGS; k++) res.args[k] = arg_val[k];
            lines_due.push_back(res);
            clear_line();
        end else if (tok_len < TOKEN_KEEP) begin
            if (tok_count == 1) begin
                if (tok_len >= WRITE_LEN) write_ok = 1'b0;
                else if (WRITE_WORD[8*(WRITE_LEN-1-tok_len) +: 8] != c) write_ok = 1'b0;
                if (tok_len >= READ_LEN) read_ok = 1'b0;
                else if (READ_WORD[8*(READ_LEN-1-tok_len) +: 8] != c) read_ok = 1'b0;
            end else begin
                slot = tok_count - 2;
                case (form)
                    FORM_DEC: begin
                        if (tok_len == 0 && c == CHAR_ZERO) begin
                            form = FORM_ZERO;
                        end else if (tok_len == 0 && c == CHAR_PLUS) begin
                            form = FORM_DEC;
                        end else if (tok_len == 0 && c == CHAR_MINUS) begin
                            neg = 1'b1;
                        end else if (dig) begin
                            arg_val[slot] = neg ? arg_val[slot] * 10 - d
                                                : arg_val[slot] * 10 + d;
                        end else begin
                            form = FORM_STOP;
                        end
                    end
                    FORM_ZERO: begin
                        if (c == CHAR_X) begin
                            form = FORM_HEX;
                        end else if (dig) begin
                            form = FORM_DEC;
                            arg_val[slot] = d;
                        end else begin
                            form = FORM_STOP;
                        end
                    end
                    FORM_HEX: begin
                        hex_ok = 1'b1;
                        nib    = '0;
                        if (dig) nib = d[3:0];
                        else if (c >= LOW_A && c <= LOW_F) nib = 4'(c - LOW_A + 8'd10);
                        else if (c >= UP_A && c <= UP_F) nib = 4'(c - UP_A + 8'd10);
                        else hex_ok = 1'b0;
                        if (hex_ok) arg_val[slot] = {arg_val[slot][27:0], nib};
                        else form = FORM_STOP;
                    end
                    default: ;
                endcase
            end
            tok_len++;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_line_result got;
        t_line_result want;
        if (!i_rst_n) begin
            clear_line();
            lines_due.delete();
        end else begin
            if (i_cmd_valid && i_cmd_ready) begin
                got.kind = i_command_kind;
                got.argc = i_arg_count;
                got.args = {i_arg4, i_arg3, i_arg2, i_arg1, i_arg0};
                if (lines_due.size() == 0) begin
                    report_mismatch("result with no line pending, arg_count", got.argc, 0);
                end else begin
                    want = lines_due.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("command_kind", got.kind, want.kind);
                    if (got.argc !== want.argc)
                        report_mismatch("arg_count", got.argc, want.argc);
                    for (int k = 0; k < OUT_ARGS; k++)
                        if (got.args[k] !== want.args[k])
                            report_mismatch($sformatf("arg%0d", k), got.args[k], want.args[k]);
                end
            end
            if (i_char_valid && i_char_ready) predict_char(i_char_in);
        end
        o_lines_pending = lines_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the tokenizer testbench: clock, reset, character lines and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cmdtok_pkg::*;

    localparam int LINE_CHARS = 1650;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_char_valid = 1'b0;
    logic [7:0]              i_char_in    = 8'h00;
    logic                    i_cmd_ready  = 1'b0;
    logic                    o_char_ready;
    logic                    o_cmd_valid;
    logic [KIND_W-1:0]       o_command_kind;
    logic [ARGC_W-1:0]       o_arg_count;
    logic signed [ARG_W-1:0] o_arg0;
    logic signed [ARG_W-1:0] o_arg1;
    logic signed [ARG_W-1:0] o_arg2;
    logic signed [ARG_W-1:0] o_arg3;
    logic signed [ARG_W-1:0] o_arg4;

    int fail_count;
    int lines_pending;
    int burst_left = 0;
    int ready_run  = 0;
    int chars_sent = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    command_line_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_valid   (i_char_valid),
        .o_char_ready   (o_char_ready),
        .i_char_in      (i_char_in),
        .o_cmd_valid    (o_cmd_valid),
        .i_cmd_ready    (i_cmd_ready),
        .o_command_kind (o_command_kind),
        .o_arg_count    (o_arg_count),
        .o_arg0         (o_arg0),
        .o_arg1         (o_arg1),
        .o_arg2         (o_arg2),
        .o_arg3         (o_arg3),
        .o_arg4         (o_arg4)
    );

    command_line_checker line_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_char_valid    (i_char_valid),
        .i_char_ready    (o_char_ready),
        .i_char_in       (i_char_in),
        .i_cmd_valid     (o_cmd_valid),
        .i_cmd_ready     (i_cmd_ready),
        .i_command_kind  (o_command_kind),
        .i_arg_count     (o_arg_count),
        .i_arg0          (o_arg0),
        .i_arg1          (o_arg1),
        .i_arg2          (o_arg2),
        .i_arg3          (o_arg3),
        .i_arg4          (o_arg4),
        .o_fail_count    (fail_count),
        .o_lines_pending (lines_pending)
    );

    // result side: short stalls, short ready runs, now and then a long ready run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cmd_ready <= 1'b0;
            ready_run   <= 0;
        end else if (ready_run == 0) begin
            case ($urandom_range(0, 5))
                0: begin
                    i_cmd_ready <= 1'b1;
                    ready_run   <= $urandom_range(50, 200);
                end
                1, 2: begin
                    i_cmd_ready <= 1'b0;
                    ready_run   <= $urandom_range(1, 8);
                end
                default: begin
                    i_cmd_ready <= 1'b1;
                    ready_run   <= $urandom_range(1, 6);
                end
            endcase
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    function automatic void text_to(ref logic [7:0] q[$], input string s);
        for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
    endfunction

    function automatic void add_from(ref logic [7:0] q[$], input string set, input int n);
        for (int k = 0; k < n; k++) q.push_back(set[$urandom_range(0, set.len() - 1)]);
    endfunction

    function automatic void add_bytes(ref logic [7:0] q[$], input int n);
        logic [7:0] b;
        for (int k = 0; k < n; k++) begin
            do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
            q.push_back(b);
        end
    endfunction

    function automatic void add_seps(ref logic [7:0] q[$], input int least);
        int n;
        n = $urandom_range(least, 3);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 2))
                0:       q.push_back(CHAR_SPACE);
                1:       q.push_back(CHAR_TAB);
                default: q.push_back(CHAR_CR);
            endcase
        end
    endfunction

    function automatic void add_arg(ref logic [7:0] q[$]);
        int    n;
        string s;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                case ($urandom_range(0, 2))
                    1:       q.push_back(CHAR_PLUS);
                    2:       q.push_back(CHAR_MINUS);
                    default: ;
                endcase
                add_from(q, "0123456789", n);
            end
            3, 4: begin
                text_to(q, "0x");
                add_from(q, "0123456789abcdefABCDEF", n);
            end
            5: begin
                case ($urandom_range(0, 6))
                    0:       s = "0";
                    1:       s = "0x";
                    2:       s = "-";
                    3:       s = "+";
                    4:       s = "0X1f";
                    5:       s = "-0x5";
                    default: s = "0x-3";
                endcase
                text_to(q, s);
            end
            6: begin
                add_from(q, "0123456789", n);
                add_from(q, "g:/+-xX", 1);
                add_from(q, "0123456789", 2);
            end
            7: begin
                text_to(q, "0x");
                add_from(q, "0123456789abcdefABCDEF", n);
                add_from(q, "gG:/@`x", 1);
                add_from(q, "0123456789abcdef", 2);
            end
            8: add_bytes(q, n);
            default: begin
                q.push_back(CHAR_ZERO);
                add_from(q, "0123456789", n);
            end
        endcase
    endfunction

    function automatic void make_line(ref logic [7:0] q[$]);
        int    nargs;
        string s;
        // blank line, possibly only separators
        if ($urandom_range(0, 19) == 0) begin
            add_seps(q, 0);
            q.push_back(CHAR_LF);
            return;
        end
        if ($urandom_range(0, 3) == 0) add_seps(q, 1);
        case ($urandom_range(0, 9))
            0, 1, 2: text_to(q, "write");
            3, 4, 5: text_to(q, "read");
            6: begin
                case ($urandom_range(0, 5))
                    0:       s = "writ";
                    1:       s = "reads";
                    2:       s = "rea";
                    3:       s = "writer";
                    4:       s = "Read";
                    default: s = "wrte";
                endcase
                text_to(q, s);
            end
            7: add_from(q, "wriead", $urandom_range(1, 6));
            8: text_to(q, "writewritewrite");
            default: add_bytes(q, $urandom_range(1, 14));
        endcase
        nargs = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
        repeat (nargs) begin
            add_seps(q, 1);
            add_arg(q);
        end
        if ($urandom_range(0, 3) == 0) add_seps(q, 1);
        q.push_back(CHAR_LF);
        // occasional noise byte anywhere, a stray newline included
        if ($urandom_range(0, 24) == 0)
            q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // sender: bursts of random length, random gaps between them
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_char_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        i_char_valid <= 1'b1;
        i_char_in    <= c;
        do @(posedge i_clk); while (!o_char_ready);
        burst_left--;
        chars_sent++;
    endtask

    task automatic send_queue(ref logic [7:0] q[$]);
        foreach (q[k]) send_char(q[k]);
    endtask

    initial begin
        logic [7:0] line_q[$];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // blank line, both commands, hex, sign, trailing separator, zero and 0xFF bytes
        text_to(line_q, "\n");
        text_to(line_q, "write 0xFF\n");
        text_to(line_q, "read\t-7 \n");
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        text_to(line_q, " +3");
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);
        send_queue(line_q);

        while (chars_sent < LINE_CHARS) begin
            line_q.delete();
            make_line(line_q);
            send_queue(line_q);
        end
        i_char_valid <= 1'b0;

        do @(negedge i_clk); while (lines_pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
